// ===== hdl/jsu_pkg.sv =====
// Shared types, codes and helper functions for the JSON string unescape block.
// Used by jsu_in_reg, jsu_decode, jsu_out_buf and json_string_unescape_utf8.
package jsu_pkg;

    // Decoder modes; the codes 6 and 7 behave as the plain body state
    localparam logic [2:0] MODE_PLAIN   = 3'd0;
    localparam logic [2:0] MODE_ESC     = 3'd1;
    localparam logic [2:0] MODE_HEX1    = 3'd2;
    localparam logic [2:0] MODE_WANT_BS = 3'd3;
    localparam logic [2:0] MODE_WANT_U  = 3'd4;
    localparam logic [2:0] MODE_HEX2    = 3'd5;

    // Completion codes
    localparam logic [3:0] ERR_OK            = 4'd0;
    localparam logic [3:0] ERR_CONTROL       = 4'd1;
    localparam logic [3:0] ERR_BAD_ESCAPE    = 4'd2;
    localparam logic [3:0] ERR_BAD_HEX       = 4'd3;
    localparam logic [3:0] ERR_NO_LOW        = 4'd4;
    localparam logic [3:0] ERR_BAD_LOW       = 4'd5;
    localparam logic [3:0] ERR_UNPAIRED_LOW  = 4'd6;
    localparam logic [3:0] ERR_OVER_BUDGET   = 4'd7;
    localparam logic [3:0] ERR_BAD_UTF8      = 4'd8;
    localparam logic [3:0] ERR_ESC_TRUNC     = 4'd9;
    localparam logic [3:0] ERR_HEX_TRUNC     = 4'd10;
    localparam logic [3:0] ERR_UNTERMINATED  = 4'd11;

    // Characters with a meaning of their own
    localparam logic [7:0] CH_QUOTE   = 8'h22;
    localparam logic [7:0] CH_BSLASH  = 8'h5c;
    localparam logic [7:0] CH_U       = 8'h75;
    localparam logic [7:0] CH_SPACE   = 8'h20;

    // Configuration register addresses (byte address, word aligned)
    localparam logic [2:0] ADDR_BUDGET = 3'd0;
    localparam logic [19:0] BUDGET_RST = 20'd65536;

    // Depth of the result buffer: most bytes one item can expand to
    localparam int unsigned BURST_MAX = 4;

    typedef struct packed {
        logic       text_end;
        logic [7:0] in_byte;
    } t_in_item;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       byte_valid;
        logic       string_done;
        logic [3:0] error_code;
    } t_result;

    typedef struct packed {
        logic [2:0]                 cnt;
        t_result [BURST_MAX-1:0]    res;
    } t_burst;

    // Incremental UTF-8 validator state
    typedef struct packed {
        logic [1:0]  remaining;
        logic [1:0]  seq_length;
        logic [20:0] code;
        logic        bad;
    } t_utf8;

    // Hex digit value; bit 4 set when the byte is a hex digit
    function automatic logic [4:0] hex_nibble(input logic [7:0] c);
        logic [4:0] r;
        r = 5'd0;
        if (c >= 8'h30 && c <= 8'h39) r = {1'b1, 4'(c - 8'h30)};
        else if (c >= 8'h61 && c <= 8'h66) r = {1'b1, 4'(c - 8'h57)};
        else if (c >= 8'h41 && c <= 8'h46) r = {1'b1, 4'(c - 8'h37)};
        return r;
    endfunction

    // Simple escape letter to byte; bit 8 set when the letter is known
    function automatic logic [8:0] simple_escape(input logic [7:0] c);
        logic [8:0] r;
        case (c)
            CH_QUOTE:  r = {1'b1, CH_QUOTE};
            CH_BSLASH: r = {1'b1, CH_BSLASH};
            8'h2f:     r = {1'b1, 8'h2f};
            8'h62:     r = {1'b1, 8'h08};
            8'h66:     r = {1'b1, 8'h0c};
            8'h6e:     r = {1'b1, 8'h0a};
            8'h72:     r = {1'b1, 8'h0d};
            8'h74:     r = {1'b1, 8'h09};
            default:   r = 9'd0;
        endcase
        return r;
    endfunction

    // Advance the UTF-8 validator by one emitted byte
    function automatic t_utf8 utf8_step(input t_utf8 s, input logic [7:0] b);
        t_utf8 r;
        r = s;
        if (!s.bad) begin
            if (s.remaining == 2'd0) begin
                if (b <= 8'h7f) begin
                    r = s;
                end else if (b >= 8'hc2 && b <= 8'hdf) begin
                    r.code = {16'd0, b[4:0]};
                    r.remaining = 2'd1;
                    r.seq_length = 2'd1;
                end else if (b >= 8'he0 && b <= 8'hef) begin
                    r.code = {17'd0, b[3:0]};
                    r.remaining = 2'd2;
                    r.seq_length = 2'd2;
                end else if (b >= 8'hf0 && b <= 8'hf4) begin
                    r.code = {18'd0, b[2:0]};
                    r.remaining = 2'd3;
                    r.seq_length = 2'd3;
                end else begin
                    r.bad = 1'b1;
                end
            end else if (b[7:6] != 2'b10) begin
                r.bad = 1'b1;
            end else begin
                r.code = {s.code[14:0], b[5:0]};
                r.remaining = s.remaining - 2'd1;
                if (r.remaining == 2'd0) begin
                    if ((s.seq_length == 2'd2 && r.code < 21'h800) ||
                        (s.seq_length == 2'd3 && r.code < 21'h10000) ||
                        r.code > 21'h10ffff ||
                        (r.code >= 21'hd800 && r.code <= 21'hdfff)) begin
                        r.bad = 1'b1;
                    end
                end
            end
        end
        return r;
    endfunction

endpackage

// ===== hdl/jsu_in_reg.sv =====
// Input register of the unescape block: holds one accepted stream item
// until the decoder commits it. Uses jsu_pkg types.
module jsu_in_reg (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  jsu_pkg::t_in_item i_item,
    input  logic              i_take,
    output logic              o_valid,
    output jsu_pkg::t_in_item o_item
);

    logic              r_valid;
    jsu_pkg::t_in_item r_item;

    // Take a new item when empty or when the held one leaves this cycle
    assign o_ready = !r_valid || i_take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    // Payload needs no reset
    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_item <= i_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

// ===== hdl/jsu_decode.sv =====
// String decoder: escape state, hex accumulator, length counter and UTF-8
// validator; turns one item into a burst of results. Uses jsu_pkg.
module jsu_decode #(
    parameter int LENGTH_BITS = 21
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [19:0]       i_budget,
    input  jsu_pkg::t_in_item i_item,
    input  logic              i_commit,
    output jsu_pkg::t_burst   o_burst
);

    localparam int CMP_BITS = (LENGTH_BITS > 20) ? LENGTH_BITS : 20;

    logic [2:0]             r_mode, n_mode;
    logic [1:0]             r_hex_cnt, n_hex_cnt;
    logic [15:0]            r_hex_val, n_hex_val;
    logic [9:0]             r_high, n_high;
    logic [LENGTH_BITS-1:0] r_len, n_len;
    jsu_pkg::t_utf8         r_utf8, n_utf8;

    logic        w_done;
    logic [3:0]  w_err;
    logic        w_emit_cp;
    logic        w_emit_raw;
    logic [20:0] w_cp;
    logic [7:0]  w_raw;
    logic [4:0]  w_hex;
    logic [8:0]  w_esc;
    logic [15:0] w_hv;
    logic [2:0]  w_cnt;
    logic [7:0]  w_bytes [jsu_pkg::BURST_MAX];
    logic [LENGTH_BITS:0] w_sum;
    jsu_pkg::t_utf8       w_utf8 [jsu_pkg::BURST_MAX+1];

    assign w_hex = jsu_pkg::hex_nibble(i_item.in_byte);
    assign w_esc = jsu_pkg::simple_escape(i_item.in_byte);
    assign w_hv  = {r_hex_val[11:0], w_hex[3:0]};

    // Mode transitions and what this item produces
    always_comb begin
        n_mode     = r_mode;
        n_hex_cnt  = r_hex_cnt;
        n_hex_val  = r_hex_val;
        n_high     = r_high;
        w_done     = 1'b0;
        w_err      = jsu_pkg::ERR_OK;
        w_emit_cp  = 1'b0;
        w_emit_raw = 1'b0;
        w_cp       = 21'd0;
        w_raw      = i_item.in_byte;
        if (i_item.text_end) begin
            w_done = 1'b1;
            unique case (r_mode) inside
                jsu_pkg::MODE_ESC:     w_err = jsu_pkg::ERR_ESC_TRUNC;
                jsu_pkg::MODE_HEX1,
                jsu_pkg::MODE_HEX2:    w_err = jsu_pkg::ERR_HEX_TRUNC;
                jsu_pkg::MODE_WANT_BS,
                jsu_pkg::MODE_WANT_U:  w_err = jsu_pkg::ERR_NO_LOW;
                default:               w_err = jsu_pkg::ERR_UNTERMINATED;
            endcase
        end else begin
            unique case (r_mode) inside
                jsu_pkg::MODE_ESC: begin
                    n_mode = jsu_pkg::MODE_PLAIN;
                    if (w_esc[8]) begin
                        w_emit_raw = 1'b1;
                        w_raw = w_esc[7:0];
                    end else if (i_item.in_byte == jsu_pkg::CH_U) begin
                        n_mode = jsu_pkg::MODE_HEX1;
                        n_hex_cnt = 2'd0;
                        n_hex_val = 16'd0;
                    end else begin
                        w_done = 1'b1;
                        w_err = jsu_pkg::ERR_BAD_ESCAPE;
                    end
                end
                jsu_pkg::MODE_HEX1, jsu_pkg::MODE_HEX2: begin
                    if (!w_hex[4]) begin
                        w_done = 1'b1;
                        w_err = jsu_pkg::ERR_BAD_HEX;
                    end else if (r_hex_cnt != 2'd3) begin
                        n_hex_cnt = r_hex_cnt + 2'd1;
                        n_hex_val = w_hv;
                    end else begin
                        n_hex_cnt = 2'd0;
                        n_hex_val = 16'd0;
                        if (r_mode == jsu_pkg::MODE_HEX1) begin
                            if (w_hv >= 16'hd800 && w_hv <= 16'hdbff) begin
                                n_high = w_hv[9:0];
                                n_mode = jsu_pkg::MODE_WANT_BS;
                            end else if (w_hv >= 16'hdc00 && w_hv <= 16'hdfff) begin
                                w_done = 1'b1;
                                w_err = jsu_pkg::ERR_UNPAIRED_LOW;
                            end else begin
                                n_mode = jsu_pkg::MODE_PLAIN;
                                w_emit_cp = 1'b1;
                                w_cp = {5'd0, w_hv};
                            end
                        end else if (w_hv < 16'hdc00 || w_hv > 16'hdfff) begin
                            w_done = 1'b1;
                            w_err = jsu_pkg::ERR_BAD_LOW;
                        end else begin
                            // Join the pair into one supplementary code point
                            n_mode = jsu_pkg::MODE_PLAIN;
                            w_emit_cp = 1'b1;
                            w_cp = 21'h10000 + {1'b0, r_high, w_hv[9:0]};
                        end
                    end
                end
                jsu_pkg::MODE_WANT_BS: begin
                    if (i_item.in_byte != jsu_pkg::CH_BSLASH) begin
                        w_done = 1'b1;
                        w_err = jsu_pkg::ERR_NO_LOW;
                    end else begin
                        n_mode = jsu_pkg::MODE_WANT_U;
                    end
                end
                jsu_pkg::MODE_WANT_U: begin
                    if (i_item.in_byte != jsu_pkg::CH_U) begin
                        w_done = 1'b1;
                        w_err = jsu_pkg::ERR_NO_LOW;
                    end else begin
                        n_mode = jsu_pkg::MODE_HEX2;
                        n_hex_cnt = 2'd0;
                        n_hex_val = 16'd0;
                    end
                end
                default: begin
                    if (i_item.in_byte == jsu_pkg::CH_QUOTE) begin
                        w_done = 1'b1;
                        if (CMP_BITS'(r_len) > CMP_BITS'(i_budget)) begin
                            w_err = jsu_pkg::ERR_OVER_BUDGET;
                        end else if (r_utf8.bad || r_utf8.remaining != 2'd0) begin
                            w_err = jsu_pkg::ERR_BAD_UTF8;
                        end else begin
                            w_err = jsu_pkg::ERR_OK;
                        end
                    end else if (i_item.in_byte < jsu_pkg::CH_SPACE) begin
                        w_done = 1'b1;
                        w_err = jsu_pkg::ERR_CONTROL;
                    end else if (i_item.in_byte == jsu_pkg::CH_BSLASH) begin
                        n_mode = jsu_pkg::MODE_ESC;
                    end else begin
                        w_emit_raw = 1'b1;
                    end
                end
            endcase
        end
    end

    // Encode the code point as UTF-8, or pass a single byte
    always_comb begin
        w_cnt = 3'd0;
        for (int i = 0; i < jsu_pkg::BURST_MAX; i++) begin
            w_bytes[i] = 8'd0;
        end
        if (w_emit_raw) begin
            w_cnt = 3'd1;
            w_bytes[0] = w_raw;
        end else if (w_emit_cp) begin
            if (w_cp <= 21'h7f) begin
                w_cnt = 3'd1;
                w_bytes[0] = w_cp[7:0];
            end else if (w_cp <= 21'h7ff) begin
                w_cnt = 3'd2;
                w_bytes[0] = {3'b110, w_cp[10:6]};
                w_bytes[1] = {2'b10, w_cp[5:0]};
            end else if (w_cp <= 21'hffff) begin
                w_cnt = 3'd3;
                w_bytes[0] = {4'b1110, w_cp[15:12]};
                w_bytes[1] = {2'b10, w_cp[11:6]};
                w_bytes[2] = {2'b10, w_cp[5:0]};
            end else begin
                w_cnt = 3'd4;
                w_bytes[0] = {5'b11110, w_cp[20:18]};
                w_bytes[1] = {2'b10, w_cp[17:12]};
                w_bytes[2] = {2'b10, w_cp[11:6]};
                w_bytes[3] = {2'b10, w_cp[5:0]};
            end
        end
    end

    // Run the validator over the emitted bytes in order
    always_comb begin
        w_utf8[0] = r_utf8;
        for (int i = 0; i < jsu_pkg::BURST_MAX; i++) begin
            if (3'(i) < w_cnt) begin
                w_utf8[i+1] = jsu_pkg::utf8_step(w_utf8[i], w_bytes[i]);
            end else begin
                w_utf8[i+1] = w_utf8[i];
            end
        end
    end

    // Saturating length count
    assign w_sum = {1'b0, r_len} + (LENGTH_BITS+1)'(w_cnt);

    always_comb begin
        n_utf8 = w_utf8[jsu_pkg::BURST_MAX];
        n_len  = w_sum[LENGTH_BITS] ? '1 : w_sum[LENGTH_BITS-1:0];
    end

    // Build the result burst
    always_comb begin
        o_burst = '0;
        if (w_done) begin
            o_burst.cnt = 3'd1;
            o_burst.res[0].string_done = 1'b1;
            o_burst.res[0].error_code = w_err;
        end else begin
            o_burst.cnt = w_cnt;
            for (int i = 0; i < jsu_pkg::BURST_MAX; i++) begin
                o_burst.res[i].out_byte = w_bytes[i];
                o_burst.res[i].byte_valid = 1'b1;
                o_burst.res[i].error_code = jsu_pkg::ERR_OK;
            end
        end
    end

    // Commit the state; a finished string clears everything
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode    <= jsu_pkg::MODE_PLAIN;
            r_hex_cnt <= 2'd0;
            r_hex_val <= 16'd0;
            r_high    <= 10'd0;
            r_len     <= '0;
            r_utf8    <= '0;
        end else if (i_commit) begin
            if (w_done) begin
                r_mode    <= jsu_pkg::MODE_PLAIN;
                r_hex_cnt <= 2'd0;
                r_hex_val <= 16'd0;
                r_high    <= 10'd0;
                r_len     <= '0;
                r_utf8    <= '0;
            end else begin
                r_mode    <= n_mode;
                r_hex_cnt <= n_hex_cnt;
                r_hex_val <= n_hex_val;
                r_high    <= n_high;
                r_len     <= n_len;
                r_utf8    <= n_utf8;
            end
        end
    end

    // Modes past the surrogate states are never entered
    a_mode_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_mode <= jsu_pkg::MODE_HEX2)
        else $error("decoder mode out of range");

    // A finished string leaves a clean plain state behind
    a_done_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_commit && w_done) |=> (r_mode == jsu_pkg::MODE_PLAIN && r_len == '0))
        else $error("string state not cleared after completion");

    // While a high surrogate waits for the backslash or the u of its partner, the hex count is zero
    a_hex_cnt_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_mode == jsu_pkg::MODE_WANT_BS || r_mode == jsu_pkg::MODE_WANT_U)
        |-> r_hex_cnt == 2'd0)
        else $error("hex count left over between surrogates");

endmodule

// ===== hdl/jsu_out_buf.sv =====
// Result buffer: holds the burst of one item and hands it out one result
// per cycle while the receiver is ready, marking the final one. Uses jsu_pkg types.
module jsu_out_buf (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_load,
    input  jsu_pkg::t_burst  i_burst,
    input  logic             i_ready,
    output logic             o_free,
    output logic             o_valid,
    output logic             o_last,
    output jsu_pkg::t_result o_result
);

    logic [2:0]       r_rem;
    jsu_pkg::t_result r_buf [jsu_pkg::BURST_MAX];
    logic             w_take;

    assign w_take  = (r_rem != 3'd0) && i_ready;
    // Free when empty or when the final result leaves this cycle
    assign o_free  = (r_rem == 3'd0) || (r_rem == 3'd1 && i_ready);
    assign o_valid = (r_rem != 3'd0);
    assign o_last  = (r_rem == 3'd1);
    assign o_result = r_buf[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rem <= 3'd0;
        end else if (i_load) begin
            r_rem <= i_burst.cnt;
        end else if (w_take) begin
            r_rem <= r_rem - 3'd1;
        end
    end

    // Load a burst or advance the queue
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            for (int i = 0; i < jsu_pkg::BURST_MAX; i++) begin
                r_buf[i] <= i_burst.res[i];
            end
        end else if (w_take) begin
            for (int i = 0; i < jsu_pkg::BURST_MAX - 1; i++) begin
                r_buf[i] <= r_buf[i+1];
            end
        end
    end

    // Buffer never holds more than one burst
    a_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rem <= 3'(jsu_pkg::BURST_MAX))
        else $error("result buffer overfilled");

    // A load only happens once the previous burst is gone
    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_load |-> o_free)
        else $error("burst loaded over pending results");

    // A completion result is always alone and final
    a_done_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_result.string_done) |-> (o_last && !o_result.byte_valid))
        else $error("completion result not final");

endmodule

// ===== hdl/json_string_unescape_utf8.sv =====
// JSON string body decoder: one raw body byte per input item, decoded bytes
// (simple escapes, \uXXXX, surrogate pairs re-encoded as UTF-8) and one
// completion result per string on the output. An item is decoded from the
// input register into a four-entry result buffer once the buffer has room;
// it drains one result per cycle while the output is ready, so an item giving
// zero or one result then sustains one item per cycle, and an item that
// expands to several UTF-8 bytes holds the input until they have drained.
// Configure the length budget (largest decoded string length in bytes) at
// address 0 only while idle.
module json_string_unescape_utf8 #(
    parameter int LENGTH_BITS = 21
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // Input stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] in_byte
    input  logic        s_axis_tuser,   // [0] text_end
    // Result stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [7:0] out_byte, [11:8] error_code, rest 0
    output logic [1:0]  m_axis_tuser,   // [0] byte_valid, [1] string_done
    output logic        m_axis_tlast
);

    logic              w_sel_budget;
    logic [19:0]       r_max;
    jsu_pkg::t_in_item w_in_item;
    jsu_pkg::t_in_item w_held;
    logic              w_held_valid;
    logic              w_commit;
    logic              w_free;
    jsu_pkg::t_burst   w_burst;
    jsu_pkg::t_result  w_res;

    // Register write and read back
    assign pready = 1'b1;
    assign w_sel_budget = (paddr[2] == jsu_pkg::ADDR_BUDGET[2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max <= jsu_pkg::BUDGET_RST;
        end else if (psel && penable && pwrite && pready && w_sel_budget) begin
            r_max <= pwdata[19:0];
        end
    end

    assign prdata = w_sel_budget ? {12'd0, r_max} : 32'd0;

    assign w_in_item.in_byte  = s_axis_tdata;
    assign w_in_item.text_end = s_axis_tuser;

    // Decode the held item once the result buffer has room
    assign w_commit = w_held_valid && w_free;

    jsu_in_reg u_in_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_item  (w_in_item),
        .i_take  (w_commit),
        .o_valid (w_held_valid),
        .o_item  (w_held)
    );

    jsu_decode #(
        .LENGTH_BITS (LENGTH_BITS)
    ) u_decode (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_budget    (r_max),
        .i_item      (w_held),
        .i_commit    (w_commit),
        .o_burst     (w_burst)
    );

    jsu_out_buf u_out_buf (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (w_commit),
        .i_burst  (w_burst),
        .i_ready  (m_axis_tready),
        .o_free   (w_free),
        .o_valid  (m_axis_tvalid),
        .o_last   (m_axis_tlast),
        .o_result (w_res)
    );

    assign m_axis_tdata = {4'd0, w_res.error_code, w_res.out_byte};
    assign m_axis_tuser = {w_res.string_done, w_res.byte_valid};

    // Byte results carry no error code
    a_byte_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser[0]) |->
        (m_axis_tdata[11:8] == jsu_pkg::ERR_OK && !m_axis_tuser[1]))
        else $error("byte result with error or done flag");

    // Every result is either a byte or a completion
    a_one_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tuser[0] != m_axis_tuser[1]))
        else $error("result neither byte nor completion");

    // No item is decoded while the previous burst is still draining
    a_commit_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tlast) |-> !w_commit)
        else $error("item decoded while results pending");

endmodule
